### design/bsa_pkg.sv
// Shared types for the bounding sphere accumulator.
package bsa_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQ_LD,
        ST_SQ_RUN,
        ST_SQRT,
        ST_CMP,
        ST_MV_LD,
        ST_MV_RUN,
        ST_DIV,
        ST_STEP,
        ST_OUT
    } t_state;

    localparam logic [1:0] AXIS_LAST = 2'd2;

endpackage

### design/bounding_sphere_accumulator_core.sv
// Bounding sphere accumulator: incremental sphere growth with a shared shift-add datapath.
// An ignored item (negative radius) or an empty bound goes straight to the output state;
// otherwise it squares each axis offset, takes the root and compares, and when the center
// moves it runs a multiply, a divide and a step for each axis. One word at a time: ready
// returns the cycle after the result loads, and an output stall delays that further.
// Reset (synchronous, active low): center 0, radius -1.0, min_distance 1, no word pending.
module bounding_sphere_accumulator_core #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     i_cfg_we,
    input  logic [FRAC_BITS:0]                       i_cfg_wdata,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    // start_req, in_x, in_y, in_z, in_radius
    input  logic [((4*COORD_BITS+1+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    // center_x, center_y, center_z, bound_radius, nonempty, grew
    output logic [((4*COORD_BITS+2+7)/8)*8-1:0]      m_axis_tdata
);
    import bsa_pkg::*;

    localparam int W    = COORD_BITS;
    localparam int MAGW = W + 1;
    localparam int AW   = 2 * MAGW + 2;
    localparam int RTW  = AW / 2;
    localparam int TW   = RTW + 2;
    localparam int MVW  = RTW + 1;
    localparam int XW   = MVW + 2;
    localparam int CW   = $clog2(AW + 1);
    localparam int ODW  = ((4*W+2+7)/8)*8;

    localparam logic signed [W-1:0] RAD_EMPTY = -(W'(1) << FRAC_BITS);
    localparam logic signed [XW-1:0] WMAX = XW'((64'd1 << (W-1)) - 64'd1);
    localparam logic signed [XW-1:0] WMIN = -WMAX - XW'(1);

    t_state r_state, n_state;

    logic [FRAC_BITS:0]       r_min_dist;
    logic signed [W-1:0]      r_c [3];
    logic signed [W-1:0]      r_radius;
    logic signed [MAGW-1:0]   r_d [3];
    logic signed [W-1:0]      r_ir;
    logic [1:0]               r_k;
    logic [AW-1:0]            r_acc;
    logic [AW-1:0]            r_ma;
    logic [MVW-1:0]           r_mb;
    logic [CW-1:0]            r_cnt;
    logic [RTW+1:0]           r_rem;
    logic [RTW-1:0]           r_root;
    logic [MVW-1:0]           r_move;
    logic                     r_grew;
    logic                     r_ovalid;
    logic [ODW-1:0]           r_odata;

    logic                     in_acc;
    logic                     out_free;
    logic                     start_req;
    logic signed [W-1:0]      in_v [3];
    logic signed [W-1:0]      in_r;
    logic signed [W-1:0]      base_c [3];
    logic signed [W-1:0]      base_r;
    logic [MAGW-1:0]          mag_k;
    logic [RTW+3:0]           sq_rem2;
    logic [RTW+3:0]           sq_trial;
    logic [RTW:0]             dv_rem2;
    logic signed [TW-1:0]     total;
    logic signed [TW-1:0]     nr;
    logic signed [TW-1:0]     rad_ext;
    logic signed [XW-1:0]     step_sum;
    logic signed [XW-1:0]     q_ext;
    logic signed [XW-1:0]     nr_ext;
    logic [W-1:0]             step_sat;
    logic                     grows;
    logic                     moves;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_ovalid || m_axis_tready;
    assign start_req = s_axis_tdata[0];
    assign in_v[0]   = s_axis_tdata[W:1];
    assign in_v[1]   = s_axis_tdata[2*W:W+1];
    assign in_v[2]   = s_axis_tdata[3*W:2*W+1];
    assign in_r      = s_axis_tdata[4*W:3*W+1];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            base_c[i] = start_req ? '0 : r_c[i];
        end
        base_r = start_req ? RAD_EMPTY : r_radius;
    end

    assign mag_k = r_d[r_k][MAGW-1] ? MAGW'(-r_d[r_k]) : MAGW'(r_d[r_k]);

    assign sq_rem2  = {r_rem, r_acc[AW-1:AW-2]};
    assign sq_trial = {2'b00, r_root, 2'b01};
    assign dv_rem2  = {r_rem[RTW-1:0], r_acc[AW-1]};

    assign rad_ext = TW'(r_radius);
    assign total   = $signed({2'b00, r_root}) + TW'(r_ir);
    assign nr      = (rad_ext + total) >>> 1;
    assign grows   = total > rad_ext;
    assign moves   = {1'b0, r_root} > (RTW+1)'(r_min_dist);
    assign nr_ext  = XW'(nr);

    assign q_ext    = $signed({2'b00, r_acc[MVW-1:0]});
    assign step_sum = XW'(r_c[r_k]) + (r_d[r_k][MAGW-1] ? -q_ext : q_ext);
    assign step_sat = (step_sum > WMAX) ? WMAX[W-1:0] :
                      (step_sum < WMIN) ? WMIN[W-1:0] : step_sum[W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (in_r[W-1] || base_r[W-1]) n_state = ST_OUT;
                    else n_state = ST_SQ_LD;
                end
            end
            ST_SQ_LD:  n_state = ST_SQ_RUN;
            ST_SQ_RUN: begin
                if (r_cnt == CW'(1)) n_state = (r_k == AXIS_LAST) ? ST_SQRT : ST_SQ_LD;
            end
            ST_SQRT: begin
                if (r_cnt == CW'(1)) n_state = ST_CMP;
            end
            ST_CMP:    n_state = (grows && moves) ? ST_MV_LD : ST_OUT;
            ST_MV_LD:  n_state = ST_MV_RUN;
            ST_MV_RUN: begin
                if (r_cnt == CW'(1)) n_state = ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == CW'(1)) n_state = ST_STEP;
            end
            ST_STEP:   n_state = (r_k == AXIS_LAST) ? ST_OUT : ST_MV_LD;
            ST_OUT: begin
                if (out_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        m_axis_tvalid = r_ovalid;
        m_axis_tdata  = r_odata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_min_dist <= (FRAC_BITS+1)'(1);
            r_c[0]     <= '0;
            r_c[1]     <= '0;
            r_c[2]     <= '0;
            r_radius   <= RAD_EMPTY;
            r_ovalid   <= 1'b0;
            r_grew     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_min_dist <= i_cfg_wdata;
            if (r_ovalid && m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_ir   <= in_r;
                        r_k    <= '0;
                        r_acc  <= '0;
                        r_grew <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            r_d[i] <= MAGW'(in_v[i]) - MAGW'(base_c[i]);
                            r_c[i] <= base_c[i];
                        end
                        r_radius <= base_r;
                        if (!in_r[W-1] && base_r[W-1]) begin
                            for (int i = 0; i < 3; i++) r_c[i] <= in_v[i];
                            r_radius <= in_r;
                            r_grew   <= 1'b1;
                        end
                    end
                end
                ST_SQ_LD: begin
                    r_ma  <= AW'(mag_k);
                    r_mb  <= MVW'(mag_k);
                    r_cnt <= CW'(MAGW);
                end
                ST_SQ_RUN, ST_MV_RUN: begin
                    if (r_mb[0]) r_acc <= r_acc + r_ma;
                    r_ma  <= r_ma << 1;
                    r_mb  <= r_mb >> 1;
                    r_cnt <= r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        if (r_state == ST_SQ_RUN) begin
                            r_k    <= r_k + 2'd1;
                            r_rem  <= '0;
                            r_root <= '0;
                            if (r_k == AXIS_LAST) r_cnt <= CW'(RTW);
                        end else begin
                            r_rem <= '0;
                            r_cnt <= CW'(AW);
                        end
                    end
                end
                ST_SQRT: begin
                    r_acc <= r_acc << 2;
                    r_cnt <= r_cnt - CW'(1);
                    if (sq_rem2 >= sq_trial) begin
                        r_rem  <= (RTW+2)'(sq_rem2 - sq_trial);
                        r_root <= {r_root[RTW-2:0], 1'b1};
                    end else begin
                        r_rem  <= (RTW+2)'(sq_rem2);
                        r_root <= {r_root[RTW-2:0], 1'b0};
                    end
                end
                ST_CMP: begin
                    r_k <= '0;
                    if (grows) begin
                        r_move   <= MVW'(nr - rad_ext);
                        r_grew   <= 1'b1;
                        r_radius <= (nr_ext > WMAX) ? WMAX[W-1:0] : nr[W-1:0];
                    end
                end
                ST_MV_LD: begin
                    r_ma  <= AW'(mag_k);
                    r_mb  <= r_move;
                    r_acc <= '0;
                    r_cnt <= CW'(MVW);
                end
                ST_DIV: begin
                    r_cnt <= r_cnt - CW'(1);
                    if (dv_rem2 >= {1'b0, r_root}) begin
                        r_rem <= (RTW+2)'(dv_rem2 - {1'b0, r_root});
                        r_acc <= {r_acc[AW-2:0], 1'b1};
                    end else begin
                        r_rem <= (RTW+2)'(dv_rem2);
                        r_acc <= {r_acc[AW-2:0], 1'b0};
                    end
                end
                ST_STEP: begin
                    r_c[r_k] <= step_sat;
                    r_k      <= r_k + 2'd1;
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= ODW'({r_grew, !r_radius[W-1], r_radius,
                                          r_c[2], r_c[1], r_c[0]});
                    end
                end
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !(r_state == ST_SQRT || r_state == ST_DIV))
        else $error("ready while busy");

    a_grew_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (!r_odata[4*W+1] || r_odata[4*W]))
        else $error("grew with empty bound");

    a_loop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SQRT || r_state == ST_DIV || r_state == ST_MV_RUN) |-> r_cnt != '0)
        else $error("iteration counter underflow");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free) |=> r_ovalid && r_state == ST_IDLE)
        else $error("result word not loaded");

endmodule

### test/bsa_checker.sv
`timescale 1ns / 1ps
// Sphere-growth predictor and output word comparator for the bounding sphere accumulator.
module bsa_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [16:0]  i_cfg_wdata,
    input  logic         s_valid,
    input  logic         s_ready,
    input  logic [135:0] s_data,
    input  logic         m_valid,
    input  logic         m_ready,
    input  logic [135:0] m_data,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_grew_count,
    output int           o_moved_count
);

    typedef struct packed {
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [31:0] rad;
        logic        nonempty;
        logic        grew;
    } t_bound;

    t_bound sphere_q[$];
    logic signed [63:0] ctr_x, ctr_y, ctr_z, rad;
    logic [16:0] min_dist;

    localparam logic signed [63:0] WMAX = 64'sd2147483647;
    localparam logic signed [63:0] WMIN = -64'sd2147483648;

    function automatic logic signed [63:0] clamp(input logic signed [63:0] v);
        if (v > WMAX) return WMAX;
        if (v < WMIN) return WMIN;
        return v;
    endfunction

    function automatic logic [63:0] isqrt(input logic [127:0] n);
        logic [63:0] r;
        logic [63:0] c;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            if (128'(c) * 128'(c) <= n) r = c;
        end
        return r;
    endfunction

    function automatic logic signed [63:0] shift_axis(input logic signed [63:0] c,
            input logic signed [63:0] d, input logic [63:0] mv, input logic [63:0] span);
        logic [127:0] q;
        logic [63:0] m;
        m = d < 0 ? 64'(-d) : 64'(d);
        q = (128'(m) * 128'(mv)) / 128'(span);
        return clamp(d < 0 ? c - $signed(q[63:0]) : c + $signed(q[63:0]));
    endfunction

    task automatic grow_bound(input logic [135:0] w);
        logic signed [63:0] ix, iy, iz, ir, dx, dy, dz, total, nr;
        logic [127:0] sq;
        logic [63:0] span, mv, ax, ay, az;
        logic g;
        t_bound e;
        ix = 64'($signed(w[32:1]));
        iy = 64'($signed(w[64:33]));
        iz = 64'($signed(w[96:65]));
        ir = 64'($signed(w[128:97]));
        g = 0;
        if (w[0]) begin
            ctr_x = 0; ctr_y = 0; ctr_z = 0; rad = -64'sd65536;
        end
        if (ir >= 0) begin
            if (rad < 0) begin
                ctr_x = ix; ctr_y = iy; ctr_z = iz; rad = ir; g = 1;
            end else begin
                dx = ix - ctr_x; dy = iy - ctr_y; dz = iz - ctr_z;
                ax = dx < 0 ? 64'(-dx) : 64'(dx);
                ay = dy < 0 ? 64'(-dy) : 64'(dy);
                az = dz < 0 ? 64'(-dz) : 64'(dz);
                sq = 128'(ax) * 128'(ax) + 128'(ay) * 128'(ay) + 128'(az) * 128'(az);
                span = isqrt(sq);
                total = $signed(span) + ir;
                if (total > rad) begin
                    nr = (rad + total) / 2;
                    mv = 64'(nr - rad);
                    if (span > 64'(min_dist)) begin
                        ctr_x = shift_axis(ctr_x, dx, mv, span);
                        ctr_y = shift_axis(ctr_y, dy, mv, span);
                        ctr_z = shift_axis(ctr_z, dz, mv, span);
                        o_moved_count++;
                    end
                    rad = clamp(nr);
                    g = 1;
                end
            end
        end
        if (g) o_grew_count++;
        e.cx = ctr_x[31:0]; e.cy = ctr_y[31:0]; e.cz = ctr_z[31:0];
        e.rad = rad[31:0]; e.nonempty = rad >= 0; e.grew = g;
        sphere_q.push_back(e);
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    assign o_pending = sphere_q.size();

    always @(posedge i_clk) begin
        t_bound e;
        if (!i_rst_n) begin
            ctr_x = 0; ctr_y = 0; ctr_z = 0; rad = -64'sd65536; min_dist = 17'd1;
            o_fail_count = 0; o_grew_count = 0; o_moved_count = 0;
        end else begin
            if (i_cfg_we) min_dist = i_cfg_wdata;
            if (m_valid && m_ready) begin
                if (sphere_q.size() == 0) begin
                    $display("unexpected output word at %0t", $realtime);
                    o_fail_count++;
                end else begin
                    e = sphere_q.pop_front();
                    if (m_data[31:0] !== e.cx) report("center_x", m_data[31:0], e.cx);
                    if (m_data[63:32] !== e.cy) report("center_y", m_data[63:32], e.cy);
                    if (m_data[95:64] !== e.cz) report("center_z", m_data[95:64], e.cz);
                    if (m_data[127:96] !== e.rad) report("radius", m_data[127:96], e.rad);
                    if (m_data[128] !== e.nonempty)
                        report("nonempty", 32'(m_data[128]), 32'(e.nonempty));
                    if (m_data[129] !== e.grew) report("grew", 32'(m_data[129]), 32'(e.grew));
                end
            end
            if (s_valid && s_ready) grow_bound(s_data);
        end
    end

endmodule

### test/tb_bounding_sphere_accumulator_core.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the bounding sphere accumulator.
module tb_bounding_sphere_accumulator_core;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic [16:0]  i_cfg_wdata = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata = 0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    logic [135:0] m_axis_tdata;
    int fail_count, pending, grew_count, moved_count;
    int sent;
    bit calm;

    always #2 i_clk = ~i_clk;

    bounding_sphere_accumulator_core dut (.*);

    bsa_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .s_valid(s_axis_tvalid), .s_ready(s_axis_tready), .s_data(s_axis_tdata),
        .m_valid(m_axis_tvalid), .m_ready(m_axis_tready), .m_data(m_axis_tdata),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_grew_count(grew_count), .o_moved_count(moved_count)
    );

    initial begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    // random receiver stalls
    always @(posedge i_clk) begin
        if (calm || $urandom_range(0, 3) != 0) begin
            m_axis_tready <= 1;
        end else begin
            m_axis_tready <= 0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
            m_axis_tready <= 1;
        end
    end

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7fffffff;
            2: return 32'h80000000;
            default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
        endcase
    endfunction

    task automatic send_word(input logic st, input logic [31:0] x, input logic [31:0] y,
            input logic [31:0] z, input logic [31:0] r);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata <= {7'd0, r, z, y, x, st};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic set_min_dist(input logic [16:0] v);
        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    initial begin
        logic [31:0] r;
        sent = 0;
        calm = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: empty copy, inside, grow, moves, ignored, extremes
        send_word(0, 32'h0, 32'h0, 32'h0, 32'hffff0000);
        send_word(0, 32'h0, 32'h0, 32'h0, 32'h00010000);
        send_word(0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(0, 32'h00050000, 32'h0, 32'h0, 32'h0);
        send_word(0, 32'hfff00000, 32'h00030000, 32'h0, 32'h00020000);
        send_word(0, 32'h0, 32'h0, 32'h1, 32'h0);
        send_word(1, 32'h1, 32'h2, 32'h3, 32'h80000000);
        send_word(0, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0);
        send_word(0, 32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff);
        send_word(0, 32'h80000000, 32'h0, 32'h7fffffff, 32'h7fffffff);
        send_word(1, 32'hffffffff, 32'h0, 32'h0, 32'h0);
        send_word(0, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(0, 32'h0, 32'h0, 32'h0, 32'h00008000);
        set_min_dist(17'h10000);
        send_word(1, 32'h0, 32'h0, 32'h0, 32'h0);
        send_word(0, 32'h00010000, 32'h0, 32'h0, 32'h0);
        send_word(0, 32'h00020000, 32'h0, 32'h0, 32'h0);
        send_word(0, 32'h00008000, 32'h0, 32'h0, 32'h7fffffff);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: set_min_dist(17'd0);
                1: set_min_dist(17'h1ffff);
                2: set_min_dist(17'($urandom));
                default: set_min_dist(17'd1);
            endcase
            for (int i = 0; i < 345; i++) begin
                if (ph == 3 && i > 250) calm = 1;
                case ($urandom_range(0, 9))
                    0: r = $urandom;
                    1: r = 32'h0;
                    default: r = $urandom_range(0, 8 << 16);
                endcase
                send_word($urandom_range(0, 15) == 0, rnd_coord(), rnd_coord(), rnd_coord(), r);
            end
        end
        s_axis_tvalid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
        $display("sent %0d words; %0d grew the bound, %0d moved its center",
                 sent, grew_count, moved_count);
        if (fail_count == 0) $display("status: pass");
        else $display("status: fail");
        $finish;
    end

endmodule

### files.f
design/bsa_pkg.sv
design/bounding_sphere_accumulator_core.sv
test/bsa_checker.sv
test/tb_bounding_sphere_accumulator_core.sv
